### design/vfcd_pkg.sv
// Shared types and constants of the video frame capture deframer.
`default_nettype none

package vfcd_pkg;

    // Field and index widths
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 15;
    localparam int FSIZE_W  = 15;
    localparam int FILL_W   = 16;
    localparam int CNT_W    = 32;
    localparam int IDX_W    = 17;   // holds any store index and the store depth itself
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_BAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REORDER    = 2'd2;

    localparam logic [FSIZE_W-1:0] FRAME_SIZE_RESET = 15'd23040;

    // Frame and screen geometry
    localparam int SYNC_BIT = 7;
    localparam logic [FILL_W-1:0] MIN_FRAME_BYTES = 16'd90;
    localparam logic [7:0] PIX_H = 8'd88;
    localparam logic [IDX_W-1:0] STRIP_BYTES = 17'd704;   // 88 rows x 8 pixels
    localparam logic [IDX_W-1:0] PIX_TOTAL   = 17'd11264; // 128 x 88

    // Configuration seen by the datapath
    typedef struct packed {
        logic [FSIZE_W-1:0] frame_size;
        logic               drop_bad;
        logic               reorder;
    } vfcd_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;      // write zero to both stores at the sweep index
        logic sweep_rst;     // sweep index back to zero
        logic accept;        // item taken this cycle
        logic copy_rd;       // read capture store at the sweep index for the copy
        logic push_write;    // store a captured byte and advance the fill count
        logic push_from_reg; // captured byte comes from the item latch
        logic load_result;   // load the output register
    } vfcd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic copy_last;
        logic is_push;
        logic defer_write;   // push that commits a frame needs a copy first
        logic out_free;
    } vfcd_status_t;

endpackage

`default_nettype wire

### design/vfcd_ctrl.sv
// Controller state machine of the video frame capture deframer.
`default_nettype none

module vfcd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire vfcd_pkg::vfcd_status_t status,
    output vfcd_pkg::vfcd_cmd_t        cmd
);
    import vfcd_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    cmd.sweep_rst = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.sweep_rst = 1'b1;
                    if (status.defer_write)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        cmd.push_write = status.is_push;
                        state_next     = ST_RESULT;
                    end
                end
            end
            ST_COPY:
            begin
                cmd.copy_rd = 1'b1;
                if (status.copy_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                // last copied byte lands in the screen store
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.push_write    = 1'b1;
                cmd.push_from_reg = 1'b1;
                state_next        = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign item_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### design/vfcd_datapath.sv
// Datapath of the video frame capture deframer: stores, fill count, counters, output register.
`default_nettype none

module vfcd_datapath #(
    parameter int CAPTURE_DEPTH = 32768
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vfcd_pkg::vfcd_cfg_t           cfg,
    input  wire vfcd_pkg::vfcd_cmd_t           cmd,
    output vfcd_pkg::vfcd_status_t             status,
    input  wire logic                          func,
    input  wire logic [vfcd_pkg::DATA_W-1:0]   data,
    input  wire logic [vfcd_pkg::ADDR_W-1:0]   address,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [vfcd_pkg::DATA_W-1:0]        read_data,
    output logic                               committed,
    output logic                               bad_frame,
    output logic [vfcd_pkg::CNT_W-1:0]         bad_frame_count,
    output logic [vfcd_pkg::CNT_W-1:0]         frame_count
);
    import vfcd_pkg::*;

    localparam int AW = $clog2(CAPTURE_DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(CAPTURE_DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_LAST = IDX_W'(CAPTURE_DEPTH - 1);

    // Stores
    logic [DATA_W-1:0] capture_mem [CAPTURE_DEPTH];
    logic [DATA_W-1:0] screen_mem  [CAPTURE_DEPTH];

    // Control state
    logic [IDX_W-1:0]  sweep_idx_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  short_cnt_reg;
    logic [CNT_W-1:0]  good_cnt_reg;
    logic              wr_pend_reg;
    logic              res_valid_reg;

    // Payload state
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [DATA_W-1:0] cap_q_reg;
    logic [DATA_W-1:0] scr_q_reg;
    logic              func_reg;
    logic [DATA_W-1:0] data_reg;
    logic              rd_zero_reg;
    logic              committed_reg;
    logic              bad_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic              res_committed_reg;
    logic              res_bad_reg;
    logic [CNT_W-1:0]  res_short_reg;
    logic [CNT_W-1:0]  res_good_reg;

    // Frame close decision on the incoming item
    logic              close_c;
    logic              bad_c;
    logic              commit_c;
    logic [IDX_W-1:0]  copy_len;

    assign close_c  = !func && data[SYNC_BIT] && (fill_reg > MIN_FRAME_BYTES);
    assign bad_c    = fill_reg < {1'b0, cfg.frame_size};
    assign commit_c = !(cfg.drop_bad && bad_c);

    // Copy length, limited to the store depth
    always_comb
    begin
        copy_len = cfg.reorder ? PIX_TOTAL : IDX_W'(cfg.frame_size);
        if (copy_len > DEPTH_W)
        begin
            copy_len = DEPTH_W;
        end
    end

    // Screen read index: strip reorder or plain
    logic [7:0]        rd_row;
    logic [6:0]        rd_col;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_zero;

    assign rd_row = address[14:7];
    assign rd_col = address[6:0];

    always_comb
    begin
        if (cfg.reorder)
        begin
            rd_idx  = IDX_W'(rd_col[6:3]) * STRIP_BYTES + IDX_W'({rd_row[6:0], rd_col[2:0]});
            rd_zero = (rd_row >= PIX_H);
        end
        else
        begin
            rd_idx  = IDX_W'(address);
            rd_zero = (IDX_W'(address) >= DEPTH_W);
        end
    end

    // Capture write index and next fill count
    logic [FILL_W-1:0] cur;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] fill_after;
    logic [DATA_W-1:0] push_byte;
    logic              cur_ok;

    always_comb
    begin
        if (cmd.push_from_reg)
        begin
            cur       = fill_reg;
            push_byte = data_reg;
        end
        else
        begin
            cur       = close_c ? '0 : fill_reg;
            push_byte = data;
        end
        fill_inc   = cur + FILL_W'(1);
        fill_after = (fill_inc > {1'b0, cfg.frame_size}) ? '0 : fill_inc;
        cur_ok     = IDX_W'(cur) < DEPTH_W;
    end

    // Capture store: clear, push write, copy read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            capture_mem[sweep_idx_reg[AW-1:0]] <= '0;
        end
        else if (cmd.push_write && cur_ok)
        begin
            capture_mem[cur[AW-1:0]] <= push_byte;
        end
        if (cmd.copy_rd)
        begin
            cap_q_reg <= capture_mem[sweep_idx_reg[AW-1:0]];
        end
    end

    // Screen store: clear, copy write, item read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            screen_mem[sweep_idx_reg[AW-1:0]] <= '0;
        end
        else if (wr_pend_reg)
        begin
            screen_mem[wr_idx_reg[AW-1:0]] <= cap_q_reg;
        end
        if (cmd.accept)
        begin
            scr_q_reg <= screen_mem[rd_idx[AW-1:0]];
        end
    end

    // Sweep counter, copy write pipe, fill count and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
            wr_pend_reg   <= 1'b0;
            fill_reg      <= '0;
            short_cnt_reg <= '0;
            good_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.sweep_rst)
            begin
                sweep_idx_reg <= '0;
            end
            else if (cmd.clear_en || cmd.copy_rd)
            begin
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
            end
            wr_pend_reg <= cmd.copy_rd;

            if (cmd.push_write)
            begin
                fill_reg <= fill_after;
            end
            else if (cmd.accept && close_c)
            begin
                fill_reg <= '0;
            end

            if (cmd.accept && close_c)
            begin
                if (bad_c)
                begin
                    short_cnt_reg <= short_cnt_reg + CNT_W'(1);
                end
                if (commit_c)
                begin
                    good_cnt_reg <= good_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        wr_idx_reg <= sweep_idx_reg;
        if (cmd.accept)
        begin
            func_reg      <= func;
            data_reg      <= data;
            rd_zero_reg   <= rd_zero;
            committed_reg <= close_c && commit_c;
            bad_reg       <= close_c && bad_c;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_data_reg      <= (func_reg && !rd_zero_reg) ? scr_q_reg : '0;
            res_committed_reg <= committed_reg;
            res_bad_reg       <= bad_reg;
            res_short_reg     <= short_cnt_reg;
            res_good_reg      <= good_cnt_reg;
        end
    end

    // Status to the controller
    assign status.clear_last  = (sweep_idx_reg == DEPTH_LAST);
    assign status.copy_last   = (sweep_idx_reg == copy_len - IDX_W'(1));
    assign status.is_push     = !func;
    assign status.defer_write = close_c && commit_c && (copy_len != '0);
    assign status.out_free    = !res_valid_reg || result_ready;

    assign result_valid    = res_valid_reg;
    assign read_data       = res_data_reg;
    assign committed       = res_committed_reg;
    assign bad_frame       = res_bad_reg;
    assign bad_frame_count = res_short_reg;
    assign frame_count     = res_good_reg;

endmodule

`default_nettype wire

### design/video_frame_capture_deframer.sv
// Reads and pushes go through IDLE and RESULT; a new item waits until the result is loaded into
// the output register, held while it is full. A push that commits a frame copies n bytes capture
// to screen through the capture read port, one per cycle; n = frame_size (or 11264 in reorder mode),
// at most CAPTURE_DEPTH. After reset both stores are zeroed one entry a cycle, with item_ready low
// throughout. Configuration writes are taken in every cycle, including during the clearing pass.
// Top level of the video frame capture deframer: configuration registers and the two units.
`default_nettype none

module video_frame_capture_deframer #(
    parameter int CAPTURE_DEPTH = 32768
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [vfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vfcd_pkg::FSIZE_W-1:0]    cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic                            func,
    input  wire logic [vfcd_pkg::DATA_W-1:0]     data,
    input  wire logic [vfcd_pkg::ADDR_W-1:0]     address,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic [vfcd_pkg::DATA_W-1:0]          read_data,
    output logic                                 committed,
    output logic                                 bad_frame,
    output logic [vfcd_pkg::CNT_W-1:0]           bad_frame_count,
    output logic [vfcd_pkg::CNT_W-1:0]           frame_count
);
    import vfcd_pkg::*;

    vfcd_cfg_t    cfg_reg;
    vfcd_cmd_t    cmd;
    vfcd_status_t status;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_size <= FRAME_SIZE_RESET;
            cfg_reg.drop_bad   <= 1'b0;
            cfg_reg.reorder    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_SIZE: cfg_reg.frame_size <= cfg_data;
                REG_DROP_BAD:   cfg_reg.drop_bad   <= cfg_data[0];
                REG_REORDER:    cfg_reg.reorder    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    vfcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    vfcd_datapath #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .func            (func),
        .data            (data),
        .address         (address),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .read_data       (read_data),
        .committed       (committed),
        .bad_frame       (bad_frame),
        .bad_frame_count (bad_frame_count),
        .frame_count     (frame_count)
    );

endmodule

`default_nettype wire
